// ----- hdl/apr_pkg.sv -----
package apr_pkg;

  localparam int FRAMES       = 16;
  localparam int PAGE_ID_BITS = 16;
  localparam int IDX_W        = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W        = $clog2(FRAMES + 1);
  localparam int AGE_W        = 8;
  localparam int CFG_ADDR_W   = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_FRAMES_IN_USE = '0;
  localparam logic [4:0]            FRAMES_IN_USE_RST = 5'd16;

  typedef logic [PAGE_ID_BITS-1:0] page_t;

  typedef struct packed {
    logic [31:0] access_time;
    logic [15:0] page_id;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  frame_used;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
  } out_item_t;

  typedef struct packed {
    logic             valid;
    page_t            page;
    logic [AGE_W-1:0] age;
    logic             refd;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

endpackage

// ----- hdl/aging_page_replacement.sv -----
// Aging page replacement over a frame table held in one synchronous RAM. A transfer on the
// input side (start high while busy is low) takes one page reference; busy stays high until
// the result has been produced, and the result appears for exactly one cycle with out_valid
// high, so the receiver must take it then. Per reference, one pass reads every table entry
// through the single read port, ages it if the access time is later than the previous one,
// writes it back while matching and picking a victim; a final write step stores the chosen
// frame and updates the totals. A new reference can be started in the cycle the previous
// result is shown. frames_in_use lies at byte address 0 and may only be written while busy
// is low.
module aging_page_replacement (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  apr_pkg::in_item_t               in_data,
  output logic                            out_valid,
  output apr_pkg::out_item_t              out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [apr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import apr_pkg::*;

  state_t state_r, state_nxt;

  entry_t              mem [FRAMES];
  entry_t              mem_q_r;
  logic [FRAMES-1:0]   init_r;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  entry_t              mem_wdata;
  logic [IDX_W-1:0]    mem_raddr;

  logic [4:0]          frames_in_use_r;
  logic [31:0]         last_time_r;
  logic [31:0]         hit_total_r, hit_total_nxt;
  logic [31:0]         miss_total_r, miss_total_nxt;

  page_t               page_r;
  logic                age_en_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    rd_cnt_r, rd_cnt_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]    chk_idx_r, chk_idx_nxt;

  logic                found_r, found_nxt;
  logic                sel_hit_r, sel_hit_nxt;
  logic [IDX_W-1:0]    sel_idx_r, sel_idx_nxt;
  logic [AGE_W-1:0]    sel_age_r, sel_age_nxt;
  logic                best_vld_r, best_vld_nxt;
  logic [IDX_W-1:0]    best_idx_r, best_idx_nxt;
  logic [AGE_W-1:0]    best_age_r, best_age_nxt;
  page_t               best_page_r, best_page_nxt;

  logic                out_valid_r;
  out_item_t           out_data_r, out_data_nxt;

  entry_t              cur;
  entry_t              aged;
  logic                in_range;
  logic                accept;
  logic                cfg_wr;
  logic                scan_done;
  logic                fin_hit;
  logic [IDX_W-1:0]    fin_idx;

  assign accept    = start && (state_r == ST_IDLE);
  assign cfg_wr    = psel && penable && pwrite && (paddr == REG_FRAMES_IN_USE);
  assign scan_done = chk_vld_r && (chk_idx_r == IDX_W'(FRAMES - 1));
  assign busy      = (state_r != ST_IDLE);
  assign pready    = 1'b1;
  assign prdata    = (paddr == REG_FRAMES_IN_USE) ? {27'd0, frames_in_use_r} : 32'd0;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (frames_in_use_r == 5'd0) begin
      count_nxt = CNT_W'(1);
    end else if (32'(frames_in_use_r) > 32'(FRAMES)) begin
      count_nxt = CNT_W'(FRAMES);
    end else begin
      count_nxt = CNT_W'(frames_in_use_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cur = init_r[chk_idx_r] ? mem_q_r : '0;
    aged = cur;
    if (age_en_r) begin
      aged.age  = {cur.refd, cur.age[AGE_W-1:1]};
      aged.refd = 1'b0;
    end
    in_range = CNT_W'(chk_idx_r) < count_r;
    fin_hit  = found_r && sel_hit_r;
    fin_idx  = found_r ? sel_idx_r : best_idx_r;

    rd_cnt_nxt     = rd_cnt_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    mem_raddr      = rd_cnt_r[IDX_W-1:0];
    mem_we         = 1'b0;
    mem_waddr      = chk_idx_r;
    mem_wdata      = aged;
    found_nxt      = found_r;
    sel_hit_nxt    = sel_hit_r;
    sel_idx_nxt    = sel_idx_r;
    sel_age_nxt    = sel_age_r;
    best_vld_nxt   = best_vld_r;
    best_idx_nxt   = best_idx_r;
    best_age_nxt   = best_age_r;
    best_page_nxt  = best_page_r;
    hit_total_nxt  = hit_total_r;
    miss_total_nxt = miss_total_r;
    out_data_nxt   = out_data_r;

    case (state_r)
      ST_IDLE: begin
        rd_cnt_nxt   = '0;
        found_nxt    = 1'b0;
        best_vld_nxt = 1'b0;
      end
      ST_SCAN: begin
        if (rd_cnt_r < CNT_W'(FRAMES)) begin
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = rd_cnt_r[IDX_W-1:0];
          rd_cnt_nxt  = rd_cnt_r + CNT_W'(1);
        end
        if (chk_vld_r) begin
          mem_we = 1'b1;
          if (in_range && !found_r && (!aged.valid || aged.page == page_r)) begin
            found_nxt   = 1'b1;
            sel_hit_nxt = aged.valid;
            sel_idx_nxt = chk_idx_r;
            sel_age_nxt = aged.age;
          end
          if (in_range && (!best_vld_r || aged.age < best_age_r ||
              (aged.age == best_age_r && aged.page < best_page_r))) begin
            best_vld_nxt  = 1'b1;
            best_idx_nxt  = chk_idx_r;
            best_age_nxt  = aged.age;
            best_page_nxt = aged.page;
          end
        end
      end
      ST_WRITE: begin
        mem_we          = 1'b1;
        mem_waddr       = fin_idx;
        mem_wdata.valid = 1'b1;
        mem_wdata.page  = page_r;
        mem_wdata.age   = found_r ? sel_age_r : '0;
        mem_wdata.refd  = 1'b1;
        if (fin_hit) begin
          hit_total_nxt = (hit_total_r == '1) ? hit_total_r : hit_total_r + 32'd1;
        end else begin
          miss_total_nxt = (miss_total_r == '1) ? miss_total_r : miss_total_r + 32'd1;
        end
        out_data_nxt.hit        = fin_hit;
        out_data_nxt.frame_used = 4'(fin_idx);
        out_data_nxt.hit_count  = hit_total_nxt;
        out_data_nxt.miss_count = miss_total_nxt;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      init_r          <= '0;
      frames_in_use_r <= FRAMES_IN_USE_RST;
      last_time_r     <= '0;
      hit_total_r     <= '0;
      miss_total_r    <= '0;
      chk_vld_r       <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      chk_vld_r    <= chk_vld_nxt;
      out_valid_r  <= (state_r == ST_WRITE);
      hit_total_r  <= hit_total_nxt;
      miss_total_r <= miss_total_nxt;
      if (mem_we) begin
        init_r[mem_waddr] <= 1'b1;
      end
      if (cfg_wr) begin
        frames_in_use_r <= pwdata[4:0];
      end
      if (accept) begin
        last_time_r <= in_data.access_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_cnt_r    <= rd_cnt_nxt;
    chk_idx_r   <= chk_idx_nxt;
    found_r     <= found_nxt;
    sel_hit_r   <= sel_hit_nxt;
    sel_idx_r   <= sel_idx_nxt;
    sel_age_r   <= sel_age_nxt;
    best_vld_r  <= best_vld_nxt;
    best_idx_r  <= best_idx_nxt;
    best_age_r  <= best_age_nxt;
    best_page_r <= best_page_nxt;
    out_data_r  <= out_data_nxt;
    if (accept) begin
      page_r   <= PAGE_ID_BITS'(in_data.page_id);
      age_en_r <= in_data.access_time > last_time_r;
      count_r  <= count_nxt;
    end
  end

endmodule
